FILE: rtl/pwm_tmr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PWM timer package
// Request and response types, operation codes and the register map of the
// four-channel PWM timer.
// ----------------------------------------------------------------------------
package pwm_tmr_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_TICK  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  typedef logic [3:0] reg_addr_t;

  localparam reg_addr_t ADDR_CONTROL = 4'd0;
  localparam reg_addr_t ADDR_IRQ_EN  = 4'd1;
  localparam reg_addr_t ADDR_STATUS  = 4'd2;
  localparam reg_addr_t ADDR_EVENT   = 4'd3;
  localparam reg_addr_t ADDR_OUT_EN  = 4'd4;
  localparam reg_addr_t ADDR_COUNT   = 4'd5;
  localparam reg_addr_t ADDR_PRESC   = 4'd6;
  localparam reg_addr_t ADDR_RELOAD  = 4'd7;
  localparam reg_addr_t ADDR_CMP0    = 4'd8;

  localparam int CTL_ENABLE    = 0;
  localparam int CTL_ONE_PULSE = 1;
  localparam int CTL_BUFFER    = 2;

  localparam int MAX_CHANNELS = 4;

  typedef struct packed {
    op_t        operation;
    reg_addr_t  reg_addr;
    logic [15:0] write_data;
  } req_t;

  typedef struct packed {
    logic [15:0]             read_data;
    logic [MAX_CHANNELS-1:0] pwm_level;
    logic                    irq;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/pwm_timer_one_pulse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PWM timer with one-pulse mode
// Up-counting timer with prescaler, buffered reload and PWM compare channels,
// driven one request per clock while the response register is free or drained.
// ----------------------------------------------------------------------------
// Each request is a tick, a register write or a register read, and each
// request yields exactly one response in the cycle after it is taken. A new
// request is taken every clock while the response register is free or being
// drained, so the sustained rate is one request per cycle; it is set by the
// single pass of next-state logic (prescaler, counter increment and compares)
// that sits between the request handshake and the response register.
module pwm_timer_one_pulse #(
  parameter int CHANNELS    = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic req_valid,
  output                     logic req_ready,
  input  wire pwm_tmr_pkg::req_t req,
  output                     logic rsp_valid,
  input  wire                logic rsp_ready,
  output pwm_tmr_pkg::rsp_t       rsp
);

  import pwm_tmr_pkg::*;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  cnt_t              count, count_next;
  logic [15:0]       psc_cnt, psc_cnt_next;
  logic [15:0]       psc_wr, psc_wr_next;
  logic [15:0]       psc_act, psc_act_next;
  cnt_t              arr_wr, arr_wr_next;
  cnt_t              arr_act, arr_act_next;
  cnt_t              ccr_wr [CHANNELS];
  cnt_t              ccr_wr_next [CHANNELS];
  cnt_t              ccr_act [CHANNELS];
  cnt_t              ccr_act_next [CHANNELS];
  logic [2:0]        ctl, ctl_next;
  logic              ie, ie_next;
  logic              uif, uif_next;
  logic [CHANNELS-1:0] oe, oe_next;

  logic              upd;
  logic              req_fire;
  cnt_t              wdata;
  logic [15:0]       rdata;
  logic [MAX_CHANNELS-1:0] lvl;

  assign req_ready = !rsp_valid || rsp_ready;
  assign req_fire  = req_valid && req_ready;
  assign wdata     = COUNT_WIDTH'(req.write_data);

  always_comb begin
    count_next   = count;
    psc_cnt_next = psc_cnt;
    psc_wr_next  = psc_wr;
    psc_act_next = psc_act;
    arr_wr_next  = arr_wr;
    arr_act_next = arr_act;
    ccr_wr_next  = ccr_wr;
    ccr_act_next = ccr_act;
    ctl_next     = ctl;
    ie_next      = ie;
    uif_next     = uif;
    oe_next      = oe;
    upd          = 1'b0;
    rdata        = '0;

    unique case (req.operation)
      OP_TICK: begin
        if (ctl[CTL_ENABLE]) begin
          if (psc_cnt < psc_act) begin
            psc_cnt_next = psc_cnt + 16'd1;
          end else begin
            psc_cnt_next = '0;
            if (count == arr_act) begin
              count_next = '0;
              upd        = 1'b1;
            end else begin
              count_next = count + cnt_t'(1);
            end
          end
        end
      end
      OP_WRITE: begin
        unique case (req.reg_addr)
          ADDR_CONTROL: ctl_next = req.write_data[2:0];
          ADDR_IRQ_EN:  ie_next  = req.write_data[0];
          ADDR_STATUS:  uif_next = uif & req.write_data[0];
          ADDR_EVENT: begin
            if (req.write_data[0]) begin
              count_next   = '0;
              psc_cnt_next = '0;
              upd          = 1'b1;
            end
          end
          ADDR_OUT_EN:  oe_next     = req.write_data[CHANNELS-1:0];
          ADDR_COUNT:   count_next  = wdata;
          ADDR_PRESC:   psc_wr_next = req.write_data;
          ADDR_RELOAD: begin
            arr_wr_next = wdata;
            if (!ctl[CTL_BUFFER]) begin
              arr_act_next = wdata;
            end
          end
          default: begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (req.reg_addr == ADDR_CMP0 + 4'(i)) begin
                ccr_wr_next[i] = wdata;
              end
            end
          end
        endcase
      end
      OP_READ: begin
        unique case (req.reg_addr)
          ADDR_CONTROL: rdata = {13'd0, ctl};
          ADDR_IRQ_EN:  rdata = {15'd0, ie};
          ADDR_STATUS:  rdata = {15'd0, uif};
          ADDR_EVENT:   rdata = '0;
          ADDR_OUT_EN:  rdata = 16'(oe);
          ADDR_COUNT:   rdata = 16'(count);
          ADDR_PRESC:   rdata = psc_wr;
          ADDR_RELOAD:  rdata = 16'(arr_wr);
          default: begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (req.reg_addr == ADDR_CMP0 + 4'(i)) begin
                rdata = 16'(ccr_wr[i]);
              end
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    // An update event loads the shadow copies, raises the update flag and, in one-pulse mode, clears enable.
    if (upd) begin
      psc_act_next = psc_wr;
      arr_act_next = arr_wr;
      ccr_act_next = ccr_wr;
      uif_next     = 1'b1;
      if (ctl[CTL_ONE_PULSE]) begin
        ctl_next[CTL_ENABLE] = 1'b0;
      end
    end

    lvl = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      lvl[i] = oe_next[i] && (count_next < ccr_act_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      psc_cnt   <= '0;
      psc_wr    <= '0;
      psc_act   <= '0;
      arr_wr    <= '1;
      arr_act   <= '1;
      for (int i = 0; i < CHANNELS; i++) begin
        ccr_wr[i]  <= '0;
        ccr_act[i] <= '0;
      end
      ctl       <= '0;
      ie        <= 1'b0;
      uif       <= 1'b0;
      oe        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        count     <= count_next;
        psc_cnt   <= psc_cnt_next;
        psc_wr    <= psc_wr_next;
        psc_act   <= psc_act_next;
        arr_wr    <= arr_wr_next;
        arr_act   <= arr_act_next;
        ccr_wr    <= ccr_wr_next;
        ccr_act   <= ccr_act_next;
        ctl       <= ctl_next;
        ie        <= ie_next;
        uif       <= uif_next;
        oe        <= oe_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp.read_data <= rdata;
      rsp.pwm_level <= lvl;
      rsp.irq       <= uif_next & ie_next;
    end
  end

`ifndef SYNTHESIS
  a_psc_bounded: assert property (@(posedge clk) disable iff (rst)
    psc_cnt <= psc_act)
    else $error("prescale count above active prescale value");

  a_irq_tracks_state: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.irq == (uif & ie))
    else $error("response irq does not match flag and enable");

  a_disabled_tick_holds: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.operation == OP_TICK && !ctl[CTL_ENABLE]
    |=> $stable(count) && $stable(psc_cnt))
    else $error("counter moved while disabled");

  a_one_pulse_stops: assert property (@(posedge clk) disable iff (rst)
    req_fire && upd && ctl[CTL_ONE_PULSE] |=> !ctl[CTL_ENABLE] && uif)
    else $error("one-pulse update did not stop the counter");
`endif

endmodule
`default_nettype wire
